>>> src/rbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_pkg: shared types and constants of the RSA block exponentiation engine
// Item, job and configuration structs, register indexes and mode codes.
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam int CHAR_BITS    = 7;
  localparam int VALUE_BITS   = 31;
  localparam int CNT_BITS     = 3;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE            = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT        = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS         = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHARS_PER_BLOCK = 2'd3;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] in_value;
    logic                  end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] out_value;
    logic                  last_of_block;
  } out_item_t;

  typedef struct packed {
    logic                  mode;
    logic [VALUE_BITS-1:0] exponent;
    logic [VALUE_BITS-1:0] modulus;
    logic [CNT_BITS-1:0]   chars_per_block;
  } cfg_regs_t;

  // One exponentiation job: the base, whether the result is unpacked into
  // characters, and how many results it produces.
  typedef struct packed {
    logic [VALUE_BITS-1:0] base;
    logic                  decrypt;
    logic [CNT_BITS-1:0]   count;
  } job_t;

endpackage

>>> src/rbm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_front: input stage of the RSA block engine
// Packs characters into blocks in encrypt mode and turns closed blocks and
// cipher words into exponentiation jobs for the job queue.
// ----------------------------------------------------------------------------
module rbm_front #(
  parameter int MAX_CHARS = 4,
  parameter int WORD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rbm_pkg::in_item_t   in_data,
  input  rbm_pkg::cfg_regs_t  cfg,
  input  logic                q_full,
  output logic                push,
  output rbm_pkg::job_t       job
);

  localparam int CB        = rbm_pkg::CHAR_BITS;
  localparam int VB        = rbm_pkg::VALUE_BITS;
  localparam int NB        = rbm_pkg::CNT_BITS;
  localparam int PACK_BITS = MAX_CHARS * CB;

  logic [PACK_BITS-1:0] pack_acc, pack_acc_next;
  logic [NB-1:0]        held, held_next;
  logic [NB-1:0]        blk;
  logic [NB-1:0]        slot;
  logic [CB-1:0]        char_in;
  logic                 take;
  logic                 close;
  logic                 decrypt;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign decrypt  = (cfg.mode == rbm_pkg::MODE_DECRYPT);
  assign char_in  = in_data.in_value[CB-1:0];

  always_comb begin
    blk = cfg.chars_per_block;
    if (blk == '0) begin
      blk = NB'(1);
    end else if (blk > NB'(MAX_CHARS)) begin
      blk = NB'(MAX_CHARS);
    end
  end

  // A count at or above MAX_CHARS writes into the top slot; a count left at or
  // above the block size by a later size change closes the block.
  assign slot      = (held >= NB'(MAX_CHARS)) ? NB'(MAX_CHARS - 1) : held;
  assign held_next = slot + NB'(1);
  assign close     = (held_next >= blk) || in_data.end_of_message;

  always_comb begin
    pack_acc_next = pack_acc;
    for (int s = 0; s < MAX_CHARS; s++) begin
      if (slot == NB'(s)) begin
        pack_acc_next[s*CB +: CB] = pack_acc[s*CB +: CB] | char_in;
      end
    end
  end

  assign push = take && (decrypt || close);

  always_comb begin
    if (decrypt) begin
      job.base    = VB'(in_data.in_value[WORD_BITS-1:0]);
      job.decrypt = 1'b1;
      job.count   = blk;
    end else begin
      job.base    = VB'(pack_acc_next);
      job.decrypt = 1'b0;
      job.count   = NB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_acc <= '0;
      held     <= '0;
    end else if (take && !decrypt) begin
      if (close) begin
        pack_acc <= '0;
        held     <= '0;
      end else begin
        pack_acc <= pack_acc_next;
        held     <= held_next;
      end
    end
  end

endmodule

>>> src/rbm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_queue: two-entry job queue
// Decouples the input stage from the exponentiation engine.
// ----------------------------------------------------------------------------
module rbm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rbm_pkg::job_t  push_data,
  output logic           full,
  input  logic           pop,
  output rbm_pkg::job_t  pop_data,
  output logic           empty
);

  localparam int DEPTH    = 2;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  rbm_pkg::job_t        slots [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("job popped from an empty queue");

endmodule

>>> src/rbm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_back: modular exponentiation engine
// Reduces the base, then runs right-to-left square-and-multiply with two
// bit-serial interleaved modular multipliers, and emits the results.
// ----------------------------------------------------------------------------
module rbm_back #(
  parameter int MAX_CHARS = 4,
  parameter int WORD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  rbm_pkg::cfg_regs_t  cfg,
  input  logic                job_valid,
  input  rbm_pkg::job_t       job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output rbm_pkg::out_item_t  out_data
);

  localparam int W        = WORD_BITS;
  localparam int VB       = rbm_pkg::VALUE_BITS;
  localparam int CB       = rbm_pkg::CHAR_BITS;
  localparam int NB       = rbm_pkg::CNT_BITS;
  localparam int SW       = $clog2(VB);
  localparam int EW       = $clog2(W);
  localparam int IDX_BITS = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REDUCE = 2'd1;
  localparam logic [1:0] S_EXP    = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  // One step of interleaved modular multiplication: r = 2r + abit*b mod n.
  function automatic logic [W-1:0] mm_step(input logic [W-1:0] r, input logic abit,
                                           input logic [W-1:0] b, input logic [W-1:0] n);
    logic [W:0] d;
    logic [W:0] s;
    d = {r, 1'b0};
    if (d >= {1'b0, n}) d = d - {1'b0, n};
    s = d + {1'b0, (abit ? b : '0)};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[W-1:0];
  endfunction

  logic [1:0]          state;
  logic [SW-1:0]       step;
  logic [EW-1:0]       ebit;
  logic [VB-1:0]       base_sr;
  logic [W-1:0]        acc, bb, sa, sb, rp, rq;
  logic [W-1:0]        acc_next, p_step, q_step, pb;
  logic                pa_bit;
  logic                jdec;
  logic [NB-1:0]       jcnt;
  logic [IDX_BITS-1:0] emit_idx;
  logic                emit_last;
  logic                emit_fire;
  logic [W-1:0]        mod_n;
  logic [W-1:0]        expo;
  logic [VB-1:0]       acc_ext;
  logic [CB-1:0]       char_out;

  assign mod_n = cfg.modulus[W-1:0];
  assign expo  = cfg.exponent[W-1:0];

  // The product unit also performs the initial base reduction (base * 1).
  assign pa_bit = (state == S_REDUCE) ? base_sr[VB-1] : sa[W-1];
  assign pb     = (state == S_REDUCE) ? W'(1) : bb;
  assign p_step = mm_step(rp, pa_bit, pb, mod_n);
  assign q_step = mm_step(rq, sb[W-1], bb, mod_n);

  assign acc_next  = expo[ebit] ? p_step : acc;
  assign job_pop   = (state == S_IDLE) && job_valid;
  assign acc_ext   = VB'(acc);
  assign char_out  = CB'(acc_ext >> (CB * emit_idx));
  assign emit_last = !jdec || (NB'(emit_idx) + NB'(1) == jcnt);
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            base_sr <= job.base;
            jdec    <= job.decrypt;
            jcnt    <= job.count;
            rp      <= '0;
            step    <= SW'(VB - 1);
            if (mod_n < W'(2)) begin
              acc      <= '0;
              emit_idx <= '0;
              state    <= S_EMIT;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          rp      <= p_step;
          base_sr <= base_sr << 1;
          step    <= step - SW'(1);
          if (step == '0) begin
            bb    <= p_step;
            sb    <= p_step;
            acc   <= W'(1);
            sa    <= W'(1);
            rp    <= '0;
            rq    <= '0;
            step  <= SW'(W - 1);
            ebit  <= '0;
            state <= S_EXP;
          end
        end
        S_EXP: begin
          rp   <= p_step;
          rq   <= q_step;
          sa   <= sa << 1;
          sb   <= sb << 1;
          step <= step - SW'(1);
          if (step == '0) begin
            acc <= acc_next;
            bb  <= q_step;
            if (ebit == EW'(W - 1)) begin
              emit_idx <= '0;
              state    <= S_EMIT;
            end else begin
              sa   <= acc_next;
              sb   <= q_step;
              rp   <= '0;
              rq   <= '0;
              step <= SW'(W - 1);
              ebit <= ebit + EW'(1);
            end
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_data.out_value     <= jdec ? VB'(char_out) : acc_ext;
            out_data.last_of_block <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + IDX_BITS'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EXP |-> step <= SW'(W - 1)) else $error("multiply step out of range");

  a_encrypt_single: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !jdec) |-> jcnt == NB'(1))
    else $error("encrypt job with more than one result");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && jdec) |-> NB'(emit_idx) < jcnt)
    else $error("character index past block size");

endmodule

>>> src/rsa_block_modexp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_block_modexp_core: toy RSA block encrypt/decrypt engine
// Computes x^exponent mod modulus by square-and-multiply over packed blocks.
// ----------------------------------------------------------------------------
// Usage:
//   The cfg channel writes mode, exponent, modulus and chars_per_block
//   (indexes 0..3); cfg_ready is always high. Write only while the block is
//   idle. The in channel takes one transaction per cycle while the two-entry
//   job queue has room. In encrypt mode characters are packed and a closed
//   block becomes one cipher word; in decrypt mode each cipher word yields
//   chars_per_block characters, clamped to 1..MAX_CHARS, the last flagged with last_of_block.
// Sequence:
//   Each job is popped from the queue, its base is reduced mod modulus and
//   WORD_BITS square-and-multiply steps run over the exponent bits (one bit
//   of the multiplier operand per cycle per step) on the two bit-serial
//   multipliers; a modulus below 2 gives zero results directly.
//   Results then leave at one per cycle while the receiver is ready.
// Reset and stall:
//   Reset restores the register defaults (mode 0, exponent 1, modulus 128,
//   one character per block), clears the open block and empties the queue.
//   A stalled receiver holds the output register; the engine waits and the
//   queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module rsa_block_modexp_core #(
  parameter int MAX_CHARS = 4,
  parameter int WORD_BITS = 31
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rbm_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rbm_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rbm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [rbm_pkg::VALUE_BITS-1:0]       cfg_data
);

  localparam int NB = rbm_pkg::CNT_BITS;
  localparam int VB = rbm_pkg::VALUE_BITS;

  rbm_pkg::cfg_regs_t cfg;
  rbm_pkg::job_t      push_job;
  rbm_pkg::job_t      pop_job;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= rbm_pkg::MODE_ENCRYPT;
      cfg.exponent        <= VB'(1);
      cfg.modulus         <= VB'(128);
      cfg.chars_per_block <= NB'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rbm_pkg::REG_MODE:            cfg.mode            <= cfg_data[0];
        rbm_pkg::REG_EXPONENT:        cfg.exponent        <= cfg_data;
        rbm_pkg::REG_MODULUS:         cfg.modulus         <= cfg_data;
        rbm_pkg::REG_CHARS_PER_BLOCK: cfg.chars_per_block <= cfg_data[NB-1:0];
        default: ;
      endcase
    end
  end

  rbm_front #(
    .MAX_CHARS (MAX_CHARS),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  rbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_job),
    .empty     (q_empty)
  );

  rbm_back #(
    .MAX_CHARS (MAX_CHARS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!q_empty),
    .job       (pop_job),
    .job_pop   (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
